// ----- design/dfgt_pkg.sv -----
// ----------------------------------------------------------------------------
// dfgt_pkg
// Types and constants shared by the depth-first graph traversal block.
// ----------------------------------------------------------------------------
package dfgt_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxEdges    = 256;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    MODE_EDGE = 1'b0,
    MODE_WALK = 1'b1
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_CLEAR,
    ST_HEAD_RD,
    ST_PUSH,
    ST_TOP_RD,
    ST_EDGE_FETCH,
    ST_TARGET,
    ST_NEXT_HEAD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       mode;
    logic [5:0] from_vertex;
    logic [5:0] to_vertex;
  } in_item_t;

  typedef struct packed {
    logic [5:0] visited_vertex;
    logic       last;
    logic [1:0] status;
  } out_item_t;

endpackage

// ----- design/depth_first_graph_traversal_top.sv -----
// Edge request: head/tail read at accept, then edge-store write, then list write and result once the output is free.
// Range or store-full error: the result is registered at accept, with no memory access.
// Traversal request: vertices are pushed on a stack and their edges fetched one at a time,
// each new target emitted; output stalls hold the walk; one request is worked on at a time.
// Reset (async, active low) empties all lists, sets vertex_count to 64; no clearing pass.
// ----------------------------------------------------------------------------
// depth_first_graph_traversal_top
// Builds adjacency lists in memories and walks them depth first.
// ----------------------------------------------------------------------------
module depth_first_graph_traversal_top #(
  parameter int unsigned MAX_VERTICES = dfgt_pkg::MaxVertices,
  parameter int unsigned MAX_EDGES    = dfgt_pkg::MaxEdges
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dfgt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dfgt_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [6:0]          cfg_data_i
);

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned EW = $clog2(MAX_EDGES);
  localparam int unsigned PW = EW + 1;
  localparam int unsigned DW = VW + 1;

  dfgt_pkg::state_e state_q, state_d;

  logic [6:0]    vcount_q;
  logic [6:0]    n_act;
  logic [EW:0]   used_q, used_d;
  logic [MAX_VERTICES-1:0] headv_q, headv_d;
  logic [MAX_VERTICES-1:0] seen_q, seen_d;
  logic [DW-1:0] depth_q, depth_d;
  dfgt_pkg::in_item_t  req_q, req_d;
  logic [VW-1:0] vtx_q, vtx_d;
  logic [PW-1:0] cur_q, cur_d;
  logic          emit_last_q, emit_last_d;
  dfgt_pkg::out_item_t res_q, res_d;
  logic          res_vld_q, res_vld_d;
  // working register keeps the pending vertex; res_q only changes on output load
  dfgt_pkg::out_item_t work_q;

  // memories
  logic [EW-1:0] head_mem [MAX_VERTICES];
  logic [EW-1:0] tail_mem [MAX_VERTICES];
  logic [5:0]    tgt_mem  [MAX_EDGES];
  logic [PW-1:0] link_mem [MAX_EDGES];
  logic [PW-1:0] stk_mem  [MAX_VERTICES];

  logic          ht_re, ht_we_head, ht_we_tail;
  logic [VW-1:0] ht_addr;
  logic [EW-1:0] ht_wdata;
  logic [EW-1:0] head_rd_q, tail_rd_q;

  logic          e_re, e_we_tgt, e_we_link;
  logic [EW-1:0] e_addr;
  logic [PW-1:0] e_wlink;
  logic [5:0]    tgt_rd_q;
  logic [PW-1:0] link_rd_q;

  logic          s_re, s_we;
  logic [VW-1:0] s_addr;
  logic [PW-1:0] s_wdata, s_rd_q;

  always_ff @(posedge clk_i) begin
    if (ht_we_head) head_mem[ht_addr] <= ht_wdata;
    if (ht_we_tail) tail_mem[ht_addr] <= ht_wdata;
    if (ht_re) begin
      head_rd_q <= head_mem[ht_addr];
      tail_rd_q <= tail_mem[ht_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_we_tgt) tgt_mem[e_addr] <= req_q.to_vertex;
    if (e_we_link) link_mem[e_addr] <= e_wlink;
    if (e_re) begin
      tgt_rd_q  <= tgt_mem[e_addr];
      link_rd_q <= link_mem[e_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) stk_mem[s_addr] <= s_wdata;
    if (s_re) s_rd_q <= stk_mem[s_addr];
  end

  assign n_act = (vcount_q == 7'd0) ? 7'd1 :
                 (vcount_q > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_q;

  logic in_acc, res_free;
  assign in_stall_o  = (state_q != dfgt_pkg::ST_IDLE) || res_vld_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign res_free    = !res_vld_q || !out_stall_i;
  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;
  assign cfg_ready_o = 1'b1;

  logic [PW-1:0] no_edge;
  assign no_edge = '1;
  logic from_ok, to_ok, full;
  assign from_ok = {1'b0, in_data_i.from_vertex} < n_act;
  assign to_ok   = {1'b0, in_data_i.to_vertex} < n_act;
  assign full    = used_q >= (EW+1)'(MAX_EDGES);
  logic [PW-1:0] head_word;
  assign head_word = headv_q[vtx_q] ? {1'b0, head_rd_q} : no_edge;
  logic cur_none;
  assign cur_none = (s_rd_q == no_edge) || (s_rd_q >= PW'(MAX_EDGES));

  always_comb begin
    state_d = state_q;
    case (state_q)
      dfgt_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.mode == dfgt_pkg::MODE_EDGE) begin
            if (from_ok && to_ok && !full) state_d = dfgt_pkg::ST_EDGE_RD;
          end else if (from_ok) begin
            state_d = dfgt_pkg::ST_CLEAR;
          end
        end
      end
      dfgt_pkg::ST_EDGE_RD:    state_d = dfgt_pkg::ST_EDGE_WR;
      dfgt_pkg::ST_EDGE_WR:    if (res_free) state_d = dfgt_pkg::ST_IDLE;
      dfgt_pkg::ST_CLEAR:      state_d = dfgt_pkg::ST_HEAD_RD;
      dfgt_pkg::ST_HEAD_RD:    state_d = dfgt_pkg::ST_EMIT;
      dfgt_pkg::ST_PUSH:       state_d = dfgt_pkg::ST_TOP_RD;
      dfgt_pkg::ST_TOP_RD:     state_d = dfgt_pkg::ST_EDGE_FETCH;
      dfgt_pkg::ST_EDGE_FETCH: begin
        if (cur_none) begin
          state_d = (depth_q == DW'(1)) ? dfgt_pkg::ST_EMIT : dfgt_pkg::ST_TOP_RD;
        end else begin
          state_d = dfgt_pkg::ST_TARGET;
        end
      end
      dfgt_pkg::ST_TARGET: begin
        if (({1'b0, tgt_rd_q} >= n_act) || seen_q[tgt_rd_q[VW-1:0]]) begin
          state_d = dfgt_pkg::ST_TOP_RD;
        end else begin
          state_d = dfgt_pkg::ST_NEXT_HEAD;
        end
      end
      dfgt_pkg::ST_NEXT_HEAD:  state_d = dfgt_pkg::ST_EMIT;
      dfgt_pkg::ST_EMIT: begin
        if (res_free) state_d = emit_last_q ? dfgt_pkg::ST_IDLE : dfgt_pkg::ST_PUSH;
      end
      default: state_d = dfgt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    used_d = used_q; headv_d = headv_q; seen_d = seen_q; depth_d = depth_q;
    req_d = req_q; vtx_d = vtx_q; cur_d = cur_q; emit_last_d = emit_last_q;
    res_d = work_q; res_vld_d = res_vld_q && out_stall_i;
    ht_re = 1'b0; ht_we_head = 1'b0; ht_we_tail = 1'b0; ht_addr = vtx_q; ht_wdata = '0;
    e_re = 1'b0; e_we_tgt = 1'b0; e_we_link = 1'b0; e_addr = cur_q[EW-1:0];
    e_wlink = no_edge;
    s_re = 1'b0; s_we = 1'b0; s_addr = VW'(depth_q - DW'(1)); s_wdata = head_word;
    case (state_q)
      dfgt_pkg::ST_IDLE: begin
        if (in_acc) begin
          req_d = in_data_i;
          vtx_d = in_data_i.from_vertex[VW-1:0];
          if (!from_ok || (in_data_i.mode == dfgt_pkg::MODE_EDGE && !to_ok)) begin
            res_d = '{visited_vertex: 6'd0, last: 1'b1, status: dfgt_pkg::STATUS_RANGE};
            res_vld_d = 1'b1;
          end else if (in_data_i.mode == dfgt_pkg::MODE_EDGE && full) begin
            res_d = '{visited_vertex: 6'd0, last: 1'b1, status: dfgt_pkg::STATUS_FULL};
            res_vld_d = 1'b1;
          end else begin
            ht_re = 1'b1;
            ht_addr = in_data_i.from_vertex[VW-1:0];
          end
        end
      end
      dfgt_pkg::ST_EDGE_RD: begin
        e_addr = used_q[EW-1:0];
        e_we_tgt = 1'b1; e_we_link = 1'b1; e_wlink = no_edge;
      end
      dfgt_pkg::ST_EDGE_WR: begin
        if (res_free) begin
          ht_wdata = used_q[EW-1:0];
          ht_we_tail = 1'b1;
          if (!headv_q[vtx_q]) begin
            ht_we_head = 1'b1;
            headv_d[vtx_q] = 1'b1;
          end else begin
            e_addr = tail_rd_q; e_we_link = 1'b1; e_wlink = {1'b0, used_q[EW-1:0]};
          end
          used_d = used_q + 1'b1;
          res_d = '{visited_vertex: 6'd0, last: 1'b1, status: dfgt_pkg::STATUS_OK};
          res_vld_d = 1'b1;
        end
      end
      dfgt_pkg::ST_CLEAR: begin
        seen_d = '0;
        seen_d[vtx_q] = 1'b1;
        depth_d = '0;
      end
      dfgt_pkg::ST_HEAD_RD: begin
        emit_last_d = 1'b0;
        res_d = '{visited_vertex: 6'(vtx_q), last: 1'b0, status: dfgt_pkg::STATUS_OK};
      end
      dfgt_pkg::ST_PUSH: begin
        if (depth_q < DW'(MAX_VERTICES)) begin
          s_addr = VW'(depth_q); s_we = 1'b1; s_wdata = head_word;
          depth_d = depth_q + 1'b1;
        end
      end
      dfgt_pkg::ST_TOP_RD: begin
        s_re = 1'b1;
      end
      dfgt_pkg::ST_EDGE_FETCH: begin
        cur_d = s_rd_q;
        if (cur_none) begin
          depth_d = depth_q - 1'b1;
          if (depth_q == DW'(1)) begin
            emit_last_d = 1'b1;
            res_d = '{visited_vertex: 6'd0, last: 1'b1, status: dfgt_pkg::STATUS_OK};
          end
        end else begin
          e_addr = s_rd_q[EW-1:0]; e_re = 1'b1;
        end
      end
      dfgt_pkg::ST_TARGET: begin
        s_we = 1'b1; s_wdata = link_rd_q;
        vtx_d = tgt_rd_q[VW-1:0];
        ht_addr = tgt_rd_q[VW-1:0];
        ht_re = 1'b1;
      end
      dfgt_pkg::ST_NEXT_HEAD: begin
        seen_d[vtx_q] = 1'b1;
        res_d = '{visited_vertex: 6'(vtx_q), last: 1'b0, status: dfgt_pkg::STATUS_OK};
      end
      dfgt_pkg::ST_EMIT: begin
        if (res_free && !emit_last_q) begin
          res_vld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // the final result is held back until the stack empties so it can carry last
  dfgt_pkg::out_item_t pend_q, pend_d;
  logic pend_vld_q, pend_vld_d;
  always_comb begin
    pend_d = pend_q; pend_vld_d = pend_vld_q;
    if (state_q == dfgt_pkg::ST_CLEAR) pend_vld_d = 1'b0;
    if (state_q == dfgt_pkg::ST_EMIT && res_free) begin
      if (emit_last_q) begin
        pend_vld_d = 1'b0;
      end else begin
        pend_d = work_q; pend_vld_d = 1'b1;
      end
    end
  end

  dfgt_pkg::out_item_t res_o_d;
  logic res_o_vld_d;
  always_comb begin
    res_o_d = res_q; res_o_vld_d = res_vld_d;
    if (state_q == dfgt_pkg::ST_EMIT && res_free) begin
      res_o_vld_d = pend_vld_q;
      res_o_d = pend_q;
      if (emit_last_q) res_o_d.last = 1'b1;
    end else if (res_vld_d && !(res_vld_q && out_stall_i)) begin
      res_o_d = res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfgt_pkg::ST_IDLE;
      vcount_q <= 7'd64;
      used_q <= '0;
      headv_q <= '0;
      seen_q <= '0;
      depth_q <= '0;
      res_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
      emit_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) vcount_q <= cfg_data_i;
      used_q <= used_d;
      headv_q <= headv_d;
      seen_q <= seen_d;
      depth_q <= depth_d;
      res_vld_q <= res_o_vld_d;
      pend_vld_q <= pend_vld_d;
      emit_last_q <= emit_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    vtx_q <= vtx_d;
    cur_q <= cur_d;
    pend_q <= pend_d;
    work_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dfgt_pkg::ST_EMIT && res_free) res_q <= res_o_d;
    else if (res_vld_d && !(res_vld_q && out_stall_i)) res_q <= res_o_d;
  end

endmodule

// ----- design/dfgt_checker.sv -----
// ----------------------------------------------------------------------------
// dfgt_checker
// Port-level checks on the traversal block.
// ----------------------------------------------------------------------------
module dfgt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dfgt_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("bad status");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != dfgt_pkg::STATUS_OK |-> out_data_o.last)
    else $error("error result without last");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while result pending");

endmodule

bind depth_first_graph_traversal_top dfgt_checker u_dfgt_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Depth-first graph traversal testbench
// Builds graphs through edge requests and checks every status and every vertex
// of each depth-first walk against an in-bench model of the adjacency lists.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NoEdge = 511;

  class graph_scoreboard;
    int unsigned n_verts;
    int unsigned head[dfgt_pkg::MaxVertices];
    int unsigned tail[dfgt_pkg::MaxVertices];
    logic [5:0] dest[dfgt_pkg::MaxEdges];
    int unsigned link[dfgt_pkg::MaxEdges];
    int unsigned used;
    dfgt_pkg::out_item_t pending[$];
    int unsigned errors;
    int unsigned checked;

    function void clear_graph();
      n_verts = 64;
      used = 0;
      foreach (head[i]) head[i] = NoEdge;
    endfunction

    function void put(logic [5:0] v, logic l, dfgt_pkg::status_e s);
      dfgt_pkg::out_item_t r;
      r.visited_vertex = v;
      r.last = l;
      r.status = s;
      pending.push_back(r);
    endfunction

    function void note_request(dfgt_pkg::in_item_t it);
      bit seen[dfgt_pkg::MaxVertices];
      int unsigned stk[$];
      int unsigned cur;
      int unsigned t;
      if (it.mode == dfgt_pkg::MODE_EDGE) begin
        if (it.from_vertex >= n_verts || it.to_vertex >= n_verts) begin
          put(0, 1, dfgt_pkg::STATUS_RANGE);
        end else if (used >= dfgt_pkg::MaxEdges) begin
          put(0, 1, dfgt_pkg::STATUS_FULL);
        end else begin
          dest[used] = it.to_vertex;
          link[used] = NoEdge;
          if (head[it.from_vertex] == NoEdge) head[it.from_vertex] = used;
          else link[tail[it.from_vertex]] = used;
          tail[it.from_vertex] = used;
          used++;
          put(0, 1, dfgt_pkg::STATUS_OK);
        end
      end else if (it.from_vertex >= n_verts) begin
        put(0, 1, dfgt_pkg::STATUS_RANGE);
      end else begin
        seen[it.from_vertex] = 1;
        put(it.from_vertex, 0, dfgt_pkg::STATUS_OK);
        stk.push_back(head[it.from_vertex]);
        while (stk.size() > 0) begin
          cur = stk[$];
          if (cur == NoEdge || cur >= dfgt_pkg::MaxEdges) begin
            void'(stk.pop_back());
            continue;
          end
          stk[stk.size()-1] = link[cur];
          t = dest[cur];
          if (t >= n_verts || seen[t]) continue;
          seen[t] = 1;
          put(t, 0, dfgt_pkg::STATUS_OK);
          if (stk.size() < dfgt_pkg::MaxVertices) stk.push_back(head[t]);
        end
        pending[$].last = 1;
      end
    endfunction

    function void check_result(dfgt_pkg::out_item_t got);
      dfgt_pkg::out_item_t exp;
      checked++;
      if (pending.size() == 0) begin
        report_error("result with nothing outstanding", got, got);
        return;
      end
      exp = pending.pop_front();
      if (got.visited_vertex !== exp.visited_vertex) report_error("vertex", got, exp);
      if (got.last !== exp.last) report_error("last", got, exp);
      if (got.status !== exp.status) report_error("status", got, exp);
    endfunction

    function void report_error(string what, dfgt_pkg::out_item_t got,
                               dfgt_pkg::out_item_t exp);
      errors++;
      $display("ERR %s: got v=%0d l=%0d s=%0d exp v=%0d l=%0d s=%0d", what,
               got.visited_vertex, got.last, got.status,
               exp.visited_vertex, exp.last, exp.status);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  dfgt_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  dfgt_pkg::out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;

  graph_scoreboard sb = new();
  int unsigned idle_pct = 32;
  int unsigned quiet = 0;
  int unsigned requests = 0;
  int unsigned walks = 0;
  bit done = 0;

  always #10 clk = ~clk;

  depth_first_graph_traversal_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send(logic m, logic [5:0] f, logic [5:0] t);
    dfgt_pkg::in_item_t it;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    it.mode = m;
    it.from_vertex = f;
    it.to_vertex = t;
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(it);
    requests++;
    if (m == dfgt_pkg::MODE_WALK) walks++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_count(logic [6:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.n_verts = (v < 1) ? 1 : ((v > 64) ? 64 : v);
  endtask

  task automatic rand_phase(int unsigned cnt, int unsigned nv);
    int unsigned lim;
    lim = (nv < 1) ? 1 : ((nv > 64) ? 64 : nv);
    repeat (cnt) begin
      if ($urandom_range(99) < 25)
        send(dfgt_pkg::MODE_WALK,
             ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(lim - 1)),
             6'($urandom));
      else if ($urandom_range(9) == 0)
        send(dfgt_pkg::MODE_EDGE, 6'($urandom), 6'($urandom));
      else
        send(dfgt_pkg::MODE_EDGE, 6'($urandom_range(lim - 1)), 6'($urandom_range(lim - 1)));
    end
  endtask

  initial begin
    sb.clear_graph();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, both modes, range errors, walk of a small cycle
    send(dfgt_pkg::MODE_WALK, 6'd0, 6'd0);
    send(dfgt_pkg::MODE_EDGE, 6'd0, 6'd63);
    send(dfgt_pkg::MODE_EDGE, 6'd63, 6'd0);
    send(dfgt_pkg::MODE_EDGE, 6'd0, 6'd1);
    send(dfgt_pkg::MODE_EDGE, 6'd1, 6'd2);
    send(dfgt_pkg::MODE_EDGE, 6'd2, 6'd0);
    send(dfgt_pkg::MODE_EDGE, 6'd1, 6'd1);
    send(dfgt_pkg::MODE_WALK, 6'd0, 6'd63);
    send(dfgt_pkg::MODE_WALK, 6'd63, 6'd0);
    send(dfgt_pkg::MODE_WALK, 6'd42, 6'd21);
    write_count(7'd3);
    send(dfgt_pkg::MODE_EDGE, 6'd3, 6'd0);
    send(dfgt_pkg::MODE_EDGE, 6'd0, 6'd3);
    send(dfgt_pkg::MODE_WALK, 6'd3, 6'd0);
    send(dfgt_pkg::MODE_WALK, 6'd0, 6'd0);
    write_count(7'd0);
    send(dfgt_pkg::MODE_WALK, 6'd0, 6'd0);
    send(dfgt_pkg::MODE_EDGE, 6'd0, 6'd0);
    send(dfgt_pkg::MODE_WALK, 6'd1, 6'd0);
    write_count(7'd127);
    send(dfgt_pkg::MODE_WALK, 6'd63, 6'd0);
    write_count(7'd8);
    rand_phase(30, 8);
    write_count(7'd64);
    rand_phase(40, 64);
    idle_pct = 0;
    rand_phase(25, 64);
    idle_pct = 32;
    write_count(7'd2);
    rand_phase(15, 2);
    write_count(7'd64);
    // fill the edge store to hit the full status
    while (sb.used < dfgt_pkg::MaxEdges)
      send(dfgt_pkg::MODE_EDGE, 6'($urandom), 6'($urandom));
    send(dfgt_pkg::MODE_EDGE, 6'd5, 6'd6);
    rand_phase(8, 64);
    drain();
    done = 1;
    $display("Ran %0d requests, %0d walks, %0d results; vertex counts 0..127, store filled.",
             requests, walks, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- depth_first_graph_traversal_top.f -----
design/dfgt_pkg.sv
design/depth_first_graph_traversal_top.sv
design/dfgt_checker.sv
bench/tb_top.sv
